@@ src/cpg_pkg.sv @@
// ----------------------------------------------------------------------------
// cpg_pkg
// Shared widths, register codes and item types of the circle point generator.
// ----------------------------------------------------------------------------
`default_nettype none

package cpg_pkg;

   // Screen coordinate width of the result fields (valid range 10 to 16)
   localparam int COORD_WIDTH = 13;

   // Field widths
   localparam int ORIGIN_W = 11;
   localparam int CENTER_W = 11;
   localparam int RADIUS_W = 5;
   localparam int COLOR_W  = 4;

   // Signed width for origin plus center, and the working width for pixels
   localparam int SCR_W  = 14;
   localparam int CALC_W = (COORD_WIDTH > SCR_W) ? COORD_WIDTH : SCR_W;

   // Arc walker widths: x unsigned, y signed (reaches -1), decision signed
   localparam int X_W   = 7;
   localparam int Y_W   = 7;
   localparam int D_W   = 13;
   localparam int MAX_POINTS = 63;
   localparam int CNT_W = 6;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [ORIGIN_W-1:0] ORIGIN_X_RESET = 11'd320;
   localparam logic [ORIGIN_W-1:0] ORIGIN_Y_RESET = 11'd240;

   typedef enum logic {
      REG_ORIGIN_X = 1'b0,
      REG_ORIGIN_Y = 1'b1
   } reg_index_type;

   // One queued circle command, center already moved to screen space
   typedef struct packed {
      logic signed [SCR_W-1:0] sx;
      logic signed [SCR_W-1:0] sy;
      logic [RADIUS_W-1:0]     radius;
      logic [COLOR_W-1:0]      color;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Wrap a working value to the result coordinate width
   function automatic logic signed [COORD_WIDTH-1:0] to_coord(
      input logic signed [CALC_W-1:0] v);
      return v[COORD_WIDTH-1:0];
   endfunction

endpackage

`default_nettype wire

@@ src/cpg_queue.sv @@
// ----------------------------------------------------------------------------
// cpg_queue
// Short register queue of circle commands between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module cpg_queue (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       push,
   input  cpg_pkg::cmd_type          push_cmd,
   input  wire                       pop,
   output cpg_pkg::cmd_type          pop_cmd,
   output cpg_pkg::queue_status_type status
);
   import cpg_pkg::*;

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff,  count_in;
   logic                do_push, do_pop;

   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;

   // Pointer wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign pop_cmd      = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

`default_nettype wire

@@ src/cpg_front.sv @@
// ----------------------------------------------------------------------------
// cpg_front
// Register port, command intake and screen-space center of each circle.
// ----------------------------------------------------------------------------
`default_nettype none

module cpg_front (
   input  wire                                   clock,
   input  wire                                   reset,
   // command intake
   input  wire                                   start,
   output logic                                  busy,
   input  wire  signed [cpg_pkg::CENTER_W-1:0]   req_center_x,
   input  wire  signed [cpg_pkg::CENTER_W-1:0]   req_center_y,
   input  wire         [cpg_pkg::RADIUS_W-1:0]   req_radius,
   input  wire         [cpg_pkg::COLOR_W-1:0]    req_color,
   // register port
   input  wire                                   psel,
   input  wire                                   penable,
   input  wire                                   pwrite,
   input  wire         [cpg_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire         [cpg_pkg::CSR_DATA_W-1:0] pwdata,
   output logic        [cpg_pkg::CSR_DATA_W-1:0] prdata,
   output logic                                  pready,
   // to the queue
   input  cpg_pkg::queue_status_type             status,
   output logic                                  push,
   output cpg_pkg::cmd_type                      push_cmd
);
   import cpg_pkg::*;

   logic [ORIGIN_W-1:0]     origin_x_ff, origin_x_in;
   logic [ORIGIN_W-1:0]     origin_y_ff, origin_y_in;
   logic                    csr_write;
   reg_index_type           csr_index;
   logic signed [SCR_W-1:0] ox_ext, oy_ext, cx_ext, cy_ext;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = reg_index_type'(paddr[2]);

   // Register writes
   always_comb begin
      origin_x_in = origin_x_ff;
      origin_y_in = origin_y_ff;
      if (csr_write) begin
         case (csr_index)
            REG_ORIGIN_X: origin_x_in = pwdata[ORIGIN_W-1:0];
            REG_ORIGIN_Y: origin_y_in = pwdata[ORIGIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= ORIGIN_X_RESET;
         origin_y_ff <= ORIGIN_Y_RESET;
      end else begin
         origin_x_ff <= origin_x_in;
         origin_y_ff <= origin_y_in;
      end
   end

   // Register reads
   always_comb begin
      case (csr_index)
         REG_ORIGIN_X: prdata = {{(CSR_DATA_W-ORIGIN_W){1'b0}}, origin_x_ff};
         REG_ORIGIN_Y: prdata = {{(CSR_DATA_W-ORIGIN_W){1'b0}}, origin_y_ff};
         default:      prdata = '0;
      endcase
   end

   // Intake: screen center is origin plus center x, origin minus center y
   assign ox_ext = $signed({{(SCR_W-ORIGIN_W){1'b0}}, origin_x_ff});
   assign oy_ext = $signed({{(SCR_W-ORIGIN_W){1'b0}}, origin_y_ff});
   assign cx_ext = {{(SCR_W-CENTER_W){req_center_x[CENTER_W-1]}}, req_center_x};
   assign cy_ext = {{(SCR_W-CENTER_W){req_center_y[CENTER_W-1]}}, req_center_y};

   assign busy            = status.full;
   assign push            = start && !busy;
   assign push_cmd.sx     = ox_ext + cx_ext;
   assign push_cmd.sy     = oy_ext - cy_ext;
   assign push_cmd.radius = req_radius;
   assign push_cmd.color  = req_color;

endmodule

`default_nettype wire

@@ src/cpg_back.sv @@
// ----------------------------------------------------------------------------
// cpg_back
// Midpoint arc walker: one arc point and four mirrored pixels per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cpg_back (
   input  wire                                        clock,
   input  wire                                        reset,
   input  cpg_pkg::queue_status_type                  status,
   input  cpg_pkg::cmd_type                           pop_cmd,
   output logic                                       pop,
   output logic                                       rsp_valid,
   output logic signed [cpg_pkg::COORD_WIDTH-1:0]     rsp_px0,
   output logic signed [cpg_pkg::COORD_WIDTH-1:0]     rsp_py0,
   output logic signed [cpg_pkg::COORD_WIDTH-1:0]     rsp_px1,
   output logic signed [cpg_pkg::COORD_WIDTH-1:0]     rsp_py1,
   output logic signed [cpg_pkg::COORD_WIDTH-1:0]     rsp_px2,
   output logic signed [cpg_pkg::COORD_WIDTH-1:0]     rsp_py2,
   output logic signed [cpg_pkg::COORD_WIDTH-1:0]     rsp_px3,
   output logic signed [cpg_pkg::COORD_WIDTH-1:0]     rsp_py3,
   output logic        [cpg_pkg::COLOR_W-1:0]         rsp_pixel_color,
   output logic                                       rsp_last
);
   import cpg_pkg::*;

   // walker state
   logic                     active_ff, active_in;
   logic [X_W-1:0]           x_ff, x_in;
   logic signed [Y_W-1:0]    y_ff, y_in;
   logic signed [D_W-1:0]    d_ff, d_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic signed [SCR_W-1:0]  sx_ff, sy_ff;
   logic [COLOR_W-1:0]       color_ff;

   // result registers
   logic                     rsp_valid_ff;
   logic signed [COORD_WIDTH-1:0] px_pos_ff, px_neg_ff, py_pos_ff, py_neg_ff;
   logic [COLOR_W-1:0]       color_out_ff;
   logic                     last_ff;

   // step decision
   logic signed [D_W-1:0]    x_d, y_d, r_d, step_x, step_y;
   logic                     inc_x, dec_y, last_pt;
   logic signed [CALC_W-1:0] sx_c, sy_c, x_c, y_c;

   assign x_d    = $signed({{(D_W-X_W){1'b0}}, x_ff});
   assign y_d    = {{(D_W-Y_W){y_ff[Y_W-1]}}, y_ff};
   assign r_d    = $signed({{(D_W-RADIUS_W){1'b0}}, pop_cmd.radius});
   assign step_x = (x_d <<< 1) + D_W'(3);
   assign step_y = D_W'(3) - (y_d <<< 1);

   // Three-way midpoint test; the quarter-scaled tests reduce to d+y > 0
   // and d-x <= 0 since d is an integer
   always_comb begin
      if (d_ff < 0) begin
         inc_x = 1'b1;
         dec_y = (d_ff + y_d) > 0;
      end else if (d_ff > 0) begin
         inc_x = (d_ff - x_d) <= 0;
         dec_y = 1'b1;
      end else begin
         inc_x = 1'b1;
         dec_y = 1'b1;
      end
   end

   // Final point once y would drop below zero, or at the point limit
   assign last_pt = (dec_y && (y_ff == '0)) || (cnt_ff == CNT_W'(MAX_POINTS - 1));
   assign pop     = !active_ff && !status.empty;

   // Load a command or advance the walk
   always_comb begin
      active_in = active_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      d_in      = d_ff;
      cnt_in    = cnt_ff;
      if (active_ff) begin
         x_in   = x_ff + X_W'(inc_x);
         y_in   = y_ff - Y_W'(dec_y);
         d_in   = d_ff + (inc_x ? step_x : '0) + (dec_y ? step_y : '0);
         cnt_in = cnt_ff + 1'b1;
         if (last_pt) begin
            active_in = 1'b0;
         end
      end else if (pop) begin
         active_in = 1'b1;
         x_in      = '0;
         y_in      = $signed({{(Y_W-RADIUS_W){1'b0}}, pop_cmd.radius});
         d_in      = D_W'(2) - (r_d <<< 1);
         cnt_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= active_ff;
      end
   end

   // Pixel offsets from the screen center
   assign sx_c = CALC_W'(sx_ff);
   assign sy_c = CALC_W'(sy_ff);
   assign x_c  = $signed({{(CALC_W-X_W){1'b0}}, x_ff});
   assign y_c  = {{(CALC_W-Y_W){y_ff[Y_W-1]}}, y_ff};

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      d_ff   <= d_in;
      cnt_ff <= cnt_in;
      if (pop) begin
         sx_ff    <= pop_cmd.sx;
         sy_ff    <= pop_cmd.sy;
         color_ff <= pop_cmd.color;
      end
      px_pos_ff    <= to_coord(sx_c + x_c);
      px_neg_ff    <= to_coord(sx_c - x_c);
      py_pos_ff    <= to_coord(sy_c + y_c);
      py_neg_ff    <= to_coord(sy_c - y_c);
      color_out_ff <= color_ff;
      last_ff      <= last_pt;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_px0         = px_pos_ff;
   assign rsp_py0         = py_pos_ff;
   assign rsp_px1         = px_pos_ff;
   assign rsp_py1         = py_neg_ff;
   assign rsp_px2         = px_neg_ff;
   assign rsp_py2         = py_pos_ff;
   assign rsp_px3         = px_neg_ff;
   assign rsp_py3         = py_neg_ff;
   assign rsp_pixel_color = color_out_ff;
   assign rsp_last        = last_ff;

endmodule

`default_nettype wire

@@ src/circle_point_generator.sv @@
// ----------------------------------------------------------------------------
// circle_point_generator
// Midpoint circle rasterizer: one circle command in, one item of four
// mirrored screen pixels out for each point of the first-quadrant arc.
// ----------------------------------------------------------------------------
//  channel   handshake                          payload
//  --------  ---------------------------------  ------------------------------
//  command   start & !busy                      req_center_x/_y, req_radius,
//                                               req_color
//  result    rsp_valid strobe, one cycle        rsp_px0..3, rsp_py0..3,
//                                               rsp_pixel_color, rsp_last
//  csr       psel & penable & pwrite (pready=1) origin_x @0x0, origin_y @0x4
//
// A command is loaded into the arc walker in the back end, which then yields
// one arc point per cycle, up to 2*radius+1 points (63 at radius 31), and
// takes the next command only after the last point. With the walker idle, a
// taken command goes from queue to walker registers to result registers.
// A two-entry command queue lets start be taken while a circle is drawn;
// busy is high only while that queue is full. The result side cannot stall.
// Synchronous reset clears the queue and walker; registers return to 320/240.
// ----------------------------------------------------------------------------
`default_nettype none

module circle_point_generator (
   input  wire                                   clock,
   input  wire                                   reset,
   // command channel
   input  wire                                   start,
   output logic                                  busy,
   input  wire  signed [cpg_pkg::CENTER_W-1:0]   req_center_x,
   input  wire  signed [cpg_pkg::CENTER_W-1:0]   req_center_y,
   input  wire         [cpg_pkg::RADIUS_W-1:0]   req_radius,
   input  wire         [cpg_pkg::COLOR_W-1:0]    req_color,
   // result channel
   output logic                                  rsp_valid,
   output logic signed [cpg_pkg::COORD_WIDTH-1:0] rsp_px0,
   output logic signed [cpg_pkg::COORD_WIDTH-1:0] rsp_py0,
   output logic signed [cpg_pkg::COORD_WIDTH-1:0] rsp_px1,
   output logic signed [cpg_pkg::COORD_WIDTH-1:0] rsp_py1,
   output logic signed [cpg_pkg::COORD_WIDTH-1:0] rsp_px2,
   output logic signed [cpg_pkg::COORD_WIDTH-1:0] rsp_py2,
   output logic signed [cpg_pkg::COORD_WIDTH-1:0] rsp_px3,
   output logic signed [cpg_pkg::COORD_WIDTH-1:0] rsp_py3,
   output logic        [cpg_pkg::COLOR_W-1:0]    rsp_pixel_color,
   output logic                                  rsp_last,
   // register port
   input  wire                                   psel,
   input  wire                                   penable,
   input  wire                                   pwrite,
   input  wire         [cpg_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire         [cpg_pkg::CSR_DATA_W-1:0] pwdata,
   output logic        [cpg_pkg::CSR_DATA_W-1:0] prdata,
   output logic                                  pready
);
   import cpg_pkg::*;

   queue_status_type q_status;
   cmd_type          push_cmd, pop_cmd;
   logic             push, pop;

   cpg_front u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_center_x (req_center_x),
      .req_center_y (req_center_y),
      .req_radius   (req_radius),
      .req_color    (req_color),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .status       (q_status),
      .push         (push),
      .push_cmd     (push_cmd)
   );

   cpg_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .status   (q_status)
   );

   cpg_back u_back (
      .clock           (clock),
      .reset           (reset),
      .status          (q_status),
      .pop_cmd         (pop_cmd),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_px0         (rsp_px0),
      .rsp_py0         (rsp_py0),
      .rsp_px1         (rsp_px1),
      .rsp_py1         (rsp_py1),
      .rsp_px2         (rsp_px2),
      .rsp_py2         (rsp_py2),
      .rsp_px3         (rsp_px3),
      .rsp_py3         (rsp_py3),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire

@@ src/cpg_checker.sv @@
// ----------------------------------------------------------------------------
// cpg_checker
// Port-level checks of the circle point generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cpg_checker (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   busy,
   input  wire                                   rsp_valid,
   input  wire  signed [cpg_pkg::COORD_WIDTH-1:0] rsp_px0,
   input  wire  signed [cpg_pkg::COORD_WIDTH-1:0] rsp_py0,
   input  wire  signed [cpg_pkg::COORD_WIDTH-1:0] rsp_px1,
   input  wire  signed [cpg_pkg::COORD_WIDTH-1:0] rsp_py1,
   input  wire  signed [cpg_pkg::COORD_WIDTH-1:0] rsp_px2,
   input  wire  signed [cpg_pkg::COORD_WIDTH-1:0] rsp_py2,
   input  wire  signed [cpg_pkg::COORD_WIDTH-1:0] rsp_px3,
   input  wire  signed [cpg_pkg::COORD_WIDTH-1:0] rsp_py3,
   input  wire         [cpg_pkg::COLOR_W-1:0]    rsp_pixel_color,
   input  wire                                   rsp_last,
   input  wire                                   pready
);

   // Reset leaves no result in flight and the intake open
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !busy)
      else $error("result or busy seen right after reset");

   // Points of one circle come out on consecutive cycles until the last one
   a_arc_unbroken: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_valid)
      else $error("gap inside one circle's points");

   // One circle keeps its color through all its points
   a_color_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> $stable(rsp_pixel_color))
      else $error("color changed within a circle");

   // The four pixels are mirror images sharing x and y coordinates
   a_mirror: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_px0 == rsp_px1) && (rsp_px2 == rsp_px3) &&
                    (rsp_py0 == rsp_py2) && (rsp_py1 == rsp_py3))
      else $error("mirrored pixels disagree");

   // Register port never waits
   a_pready: assert property (@(posedge clock) disable iff (reset)
      pready)
      else $error("pready low");

endmodule

bind circle_point_generator cpg_checker u_cpg_checker (
   .clock           (clock),
   .reset           (reset),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_px0         (rsp_px0),
   .rsp_py0         (rsp_py0),
   .rsp_px1         (rsp_px1),
   .rsp_py1         (rsp_py1),
   .rsp_px2         (rsp_px2),
   .rsp_py2         (rsp_py2),
   .rsp_px3         (rsp_px3),
   .rsp_py3         (rsp_py3),
   .rsp_pixel_color (rsp_pixel_color),
   .rsp_last        (rsp_last),
   .pready          (pready)
);

`default_nettype wire
